/* src/fpm_pkg.sv */
// ----------------------------------------------------------------------------
// fpm_pkg: shared types and constants of the frequency and period meter
// Word types of both channels, register fields, controller commands and
// the scale tables that turn counts into milli-hertz.
// ----------------------------------------------------------------------------
package fpm_pkg;

  // Width of a frequency in milli-hertz.
  localparam int FREQ_W = 48;
  // Width of the period-mode numerator (largest is 1e13 mHz).
  localparam int NUM_W = 44;
  // Width of a gate scale factor (largest is 10000).
  localparam int SCALE_W = 14;
  // Width of the products taken for the jump check.
  localparam int CHK_W = FREQ_W + 4;

  // Input word: one finished counter value.
  typedef struct packed {
    logic        action;
    logic [31:0] count;
  } item_t;

  // Result word.
  typedef struct packed {
    logic [FREQ_W-1:0] freq_mhz;
    logic              is_error;
    logic              updated;
  } result_t;

  // Configuration register fields.
  typedef struct packed {
    logic       meter_enabled;
    logic [1:0] gate_time_sel;
    logic [1:0] ref_clock_sel;
    logic [1:0] periods_sel;
  } cfg_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch;
    logic set_period;
    logic mul;
    logic zero;
    logic div_start;
    logic div_step;
    logic check;
    logic commit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic action;
    logic period_mode;
    logic count_low;
    logic count_zero;
    logic div_last;
  } status_t;

  // Gate scales in mHz per counted edge: x10, x1 and x0.1 Hz.
  localparam logic [SCALE_W-1:0] GATE_MHZ [3] = '{
    SCALE_W'(10000), SCALE_W'(1000), SCALE_W'(100)
  };
  localparam logic [SCALE_W-1:0] GATE_MHZ_DEFAULT = SCALE_W'(10000);

  // Reference frequency in mHz times the averaged period count.
  localparam logic [NUM_W-1:0] PERIOD_NUM [4][3] = '{
    '{44'd100000000,    44'd1000000000,    44'd10000000000},
    '{44'd1000000000,   44'd10000000000,   44'd100000000000},
    '{44'd10000000000,  44'd100000000000,  44'd1000000000000},
    '{44'd100000000000, 44'd1000000000000, 44'd10000000000000}
  };
  localparam logic [NUM_W-1:0] PERIOD_NUM_DEFAULT = 44'd1000000000;

  // Selector code three behaves as code two.
  function automatic logic [1:0] sat2(input logic [1:0] sel);
    sat2 = (sel == 2'd3) ? 2'd2 : sel;
  endfunction

  // Gate scale chosen by the configuration.
  function automatic logic [SCALE_W-1:0] gate_scale(input cfg_t cfg);
    if (cfg.meter_enabled) begin
      gate_scale = GATE_MHZ[sat2(cfg.gate_time_sel)];
    end else begin
      gate_scale = GATE_MHZ_DEFAULT;
    end
  endfunction

  // Period-mode numerator chosen by the configuration.
  function automatic logic [NUM_W-1:0] period_num(input cfg_t cfg);
    if (cfg.meter_enabled) begin
      period_num = PERIOD_NUM[cfg.ref_clock_sel][sat2(cfg.periods_sel)];
    end else begin
      period_num = PERIOD_NUM_DEFAULT;
    end
  endfunction

endpackage

/* src/fpm_datapath.sv */
// ----------------------------------------------------------------------------
// fpm_datapath: arithmetic and measurement state
// Holds the latched count, the gate multiplier, a restoring divider for
// period counts, the jump check and the shown frequency and error.
// ----------------------------------------------------------------------------
module fpm_datapath #(
  parameter int COUNT_WIDTH     = 32,
  parameter int LOW_COUNT_LIMIT = 1000
) (
  input  logic                      clk,
  input  logic                      rst,
  input  fpm_pkg::cfg_t             cfg,
  input  fpm_pkg::item_t            item,
  input  fpm_pkg::cmd_t             cmd,
  output fpm_pkg::status_t          status,
  output logic [fpm_pkg::FREQ_W-1:0] shown_freq,
  output logic                      shown_error
);

  localparam int STEP_W = $clog2(fpm_pkg::NUM_W);
  localparam int PROD_W = COUNT_WIDTH + fpm_pkg::SCALE_W;

  logic                          action;
  logic [COUNT_WIDTH-1:0]        cnt;
  logic                          period_mode;
  logic [fpm_pkg::FREQ_W-1:0]    freq;
  logic [fpm_pkg::FREQ_W-1:0]    prev_freq;
  logic [fpm_pkg::CHK_W-1:0]     ten_freq;
  logic [fpm_pkg::CHK_W-1:0]     prev_x9;
  logic [fpm_pkg::CHK_W-1:0]     prev_x11;
  logic [fpm_pkg::NUM_W-1:0]     quo;
  logic [COUNT_WIDTH-1:0]        rem;
  logic [STEP_W-1:0]             step_cnt;

  logic [PROD_W-1:0]             gate_prod;
  logic [COUNT_WIDTH:0]          trial;
  logic [COUNT_WIDTH:0]          diff;
  logic                          q_bit;
  logic [fpm_pkg::NUM_W-1:0]     quo_next;
  logic [COUNT_WIDTH-1:0]        rem_next;
  logic                          jump;

  // Gate result: count times the gate scale.
  assign gate_prod = PROD_W'(cnt) * PROD_W'(fpm_pkg::gate_scale(cfg));

  // One restoring division step: shift in the next numerator bit.
  assign trial    = {rem, quo[fpm_pkg::NUM_W-1]};
  assign diff     = trial - {1'b0, cnt};
  assign q_bit    = !diff[COUNT_WIDTH];
  assign rem_next = q_bit ? diff[COUNT_WIDTH-1:0] : trial[COUNT_WIDTH-1:0];
  assign quo_next = {quo[fpm_pkg::NUM_W-2:0], q_bit};

  // A move of more than ten percent either way is a jump.
  assign jump = (ten_freq < prev_x9) || (ten_freq > prev_x11);

  // Status toward the controller.
  assign status.action      = action;
  assign status.period_mode = period_mode;
  assign status.count_low   = cnt < COUNT_WIDTH'(LOW_COUNT_LIMIT);
  assign status.count_zero  = (cnt == '0);
  assign status.div_last    = (step_cnt == STEP_W'(fpm_pkg::NUM_W - 1));

  // Measurement state, cleared by reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      period_mode <= 1'b0;
      prev_freq   <= '0;
      shown_freq  <= '0;
      shown_error <= 1'b0;
    end else begin
      if (cmd.set_period) begin
        period_mode <= 1'b1;
      end
      if (cmd.commit) begin
        period_mode <= 1'b0;
        prev_freq   <= freq;
        shown_error <= jump;
        if (!jump) begin
          shown_freq <= freq;
        end
      end
    end
  end

  // Working registers: latched word, divider, candidate value and products.
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      action <= item.action;
      cnt    <= item.count[COUNT_WIDTH-1:0];
    end
    if (cmd.mul) begin
      freq <= fpm_pkg::FREQ_W'(gate_prod);
    end
    if (cmd.zero) begin
      freq <= '0;
    end
    if (cmd.div_start) begin
      quo      <= fpm_pkg::period_num(cfg);
      rem      <= '0;
      step_cnt <= '0;
    end
    if (cmd.div_step) begin
      quo      <= quo_next;
      rem      <= rem_next;
      step_cnt <= step_cnt + 1'b1;
      if (status.div_last) begin
        freq <= fpm_pkg::FREQ_W'(quo_next);
      end
    end
    if (cmd.check) begin
      ten_freq <= {1'b0, freq, 3'b000} + {3'b000, freq, 1'b0};
      prev_x9  <= {1'b0, prev_freq, 3'b000} + {4'b0000, prev_freq};
      prev_x11 <= {1'b0, prev_freq, 3'b000} + {3'b000, prev_freq, 1'b0}
                  + {4'b0000, prev_freq};
    end
  end

endmodule

/* src/fpm_ctrl.sv */
// ----------------------------------------------------------------------------
// fpm_ctrl: sequencing of one word
// Decides what an accepted word does, runs the divider, the jump check
// and the commit, and hands the result to the output register.
// ----------------------------------------------------------------------------
module fpm_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  fpm_pkg::status_t  status,
  input  logic              out_free,
  output fpm_pkg::cmd_t     cmd,
  output logic              load_out,
  output logic              updated
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_DIV,
    S_CHECK,
    S_COMMIT,
    S_OUT
  } state_t;

  state_t state;
  state_t state_next;
  logic   upd;
  logic   upd_next;

  assign item_ready = (state == S_IDLE);
  assign updated    = upd;

  // Commands and next state.
  always_comb begin
    cmd        = '0;
    load_out   = 1'b0;
    state_next = state;
    upd_next   = upd;
    unique case (state)
      S_IDLE: begin
        if (item_valid) begin
          cmd.latch  = 1'b1;
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        upd_next = 1'b0;
        if (!status.action) begin
          if (status.period_mode) begin
            state_next = S_OUT;
          end else if (status.count_low) begin
            cmd.set_period = 1'b1;
            state_next     = S_OUT;
          end else begin
            cmd.mul    = 1'b1;
            upd_next   = 1'b1;
            state_next = S_CHECK;
          end
        end else begin
          if (!status.period_mode) begin
            state_next = S_OUT;
          end else if (status.count_zero) begin
            cmd.zero   = 1'b1;
            upd_next   = 1'b1;
            state_next = S_CHECK;
          end else begin
            cmd.div_start = 1'b1;
            upd_next      = 1'b1;
            state_next    = S_DIV;
          end
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.check  = 1'b1;
        state_next = S_COMMIT;
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          load_out   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State and the registered update flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      upd   <= 1'b0;
    end else begin
      state <= state_next;
      upd   <= upd_next;
    end
  end

endmodule

/* src/freq_period_meter_with_jump_check.sv */
// ----------------------------------------------------------------------------
// freq_period_meter_with_jump_check: frequency meter with a jump check
// Top level: configuration registers, controller, datapath and the
// registered result word.
// ----------------------------------------------------------------------------
// Each word carries a finished gate count or period count and yields one
// result word with the shown frequency in milli-hertz, the jump error and
// a flag telling whether a new value was computed. Words are handled one
// at a time. A gate count or a zero period count passes through the decide,
// check, commit and output states; an ignored word or a low gate count goes
// from decide straight to output; a nonzero period count first runs the
// restoring divider, which retires one quotient bit per cycle over the 44-bit
// numerator. The next word can be accepted in the cycle after the result is
// loaded. The result sits in an output register, so the next word is taken
// while it waits. The user must write the registers through the APB port at byte
// addresses 0, 4, 8 and 12 only while the block is idle; the block does not enforce it.
module freq_period_meter_with_jump_check #(
  parameter int COUNT_WIDTH     = 32,
  parameter int LOW_COUNT_LIMIT = 1000
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_ready,
  input  fpm_pkg::item_t      item,
  output logic                result_valid,
  input  logic                result_ready,
  output fpm_pkg::result_t    result,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam logic [1:0] REG_METER_ENABLED = 2'd0;
  localparam logic [1:0] REG_GATE_TIME_SEL = 2'd1;
  localparam logic [1:0] REG_REF_CLOCK_SEL = 2'd2;
  localparam logic [1:0] REG_PERIODS_SEL   = 2'd3;

  fpm_pkg::cfg_t               cfg;
  fpm_pkg::cmd_t               cmd;
  fpm_pkg::status_t            status;
  logic [fpm_pkg::FREQ_W-1:0]  shown_freq;
  logic                        shown_error;
  logic                        load_out;
  logic                        updated;
  logic                        out_free;
  logic                        cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign out_free  = !result_valid || result_ready;

  // Configuration register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_write) begin
      unique case (paddr[3:2])
        REG_METER_ENABLED: cfg.meter_enabled <= pwdata[0];
        REG_GATE_TIME_SEL: cfg.gate_time_sel <= pwdata[1:0];
        REG_REF_CLOCK_SEL: cfg.ref_clock_sel <= pwdata[1:0];
        REG_PERIODS_SEL:   cfg.periods_sel   <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    unique case (paddr[3:2])
      REG_METER_ENABLED: prdata = {31'd0, cfg.meter_enabled};
      REG_GATE_TIME_SEL: prdata = {30'd0, cfg.gate_time_sel};
      REG_REF_CLOCK_SEL: prdata = {30'd0, cfg.ref_clock_sel};
      REG_PERIODS_SEL:   prdata = {30'd0, cfg.periods_sel};
      default:           prdata = '0;
    endcase
  end

  fpm_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .status     (status),
    .out_free   (out_free),
    .cmd        (cmd),
    .load_out   (load_out),
    .updated    (updated)
  );

  fpm_datapath #(
    .COUNT_WIDTH     (COUNT_WIDTH),
    .LOW_COUNT_LIMIT (LOW_COUNT_LIMIT)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .item        (item),
    .cmd         (cmd),
    .status      (status),
    .shown_freq  (shown_freq),
    .shown_error (shown_error)
  );

  // Output register: holds the result word until it is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load_out) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      result.freq_mhz <= shown_freq;
      result.is_error <= shown_error;
      result.updated  <= updated;
    end
  end

endmodule

/* dv/freq_period_meter_with_jump_check_checker.sv */
// ----------------------------------------------------------------------------
// freq_period_meter_with_jump_check_checker: scoreboard of the meter
// Watches the register port and both word channels, keeps its own copy
// of the meter state, works out the reading each count word should give
// and compares every result word against the oldest reading still owed.
// ----------------------------------------------------------------------------

// Codes shared by the testbench top and the checker.
package fpm_tb_pkg;

  // Kind of counter value carried by an input word.
  typedef enum logic {
    ACT_GATE   = 1'b0,
    ACT_PERIOD = 1'b1
  } action_e;

  // Register indexes; the byte address is four times the index.
  localparam int REG_METER_ENABLED = 0;
  localparam int REG_GATE_TIME     = 1;
  localparam int REG_REF_CLOCK     = 2;
  localparam int REG_PERIODS       = 3;

  // Selector codes. Code three of the gate and periods selectors acts as two.
  localparam logic [1:0] GATE_SEL_X10   = 2'd0;
  localparam logic [1:0] GATE_SEL_X1    = 2'd1;
  localparam logic [1:0] GATE_SEL_X0P1  = 2'd2;
  localparam logic [1:0] REF_SEL_100K   = 2'd0;
  localparam logic [1:0] REF_SEL_100M   = 2'd3;
  localparam logic [1:0] PER_SEL_X1     = 2'd0;
  localparam logic [1:0] PER_SEL_X100   = 2'd2;
  localparam logic [1:0] SEL_SATURATING = 2'd3;

  // Gate counts below this switch the meter to period mode.
  localparam int LOW_COUNT_LIMIT = 1000;

endpackage

module freq_period_meter_with_jump_check_checker (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  input  logic              item_ready,
  input  fpm_pkg::item_t    item,
  input  logic              result_valid,
  input  logic              result_ready,
  input  fpm_pkg::result_t  result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  output int                mismatches,
  output int                outstanding
);

  timeunit 1ns;
  timeprecision 1ps;

  // Shadow copy of the configuration registers.
  logic       cfg_enabled;
  logic [1:0] cfg_gate_sel;
  logic [1:0] cfg_ref_sel;
  logic [1:0] cfg_per_sel;

  // Shadow copy of the meter state.
  logic        in_period_mode;
  logic [63:0] last_freq;
  logic [47:0] shown_freq;
  logic        shown_jump;

  fpm_pkg::result_t expected_readings[$];
  fpm_pkg::result_t owed;
  int               fail_count;

  assign mismatches  = fail_count;
  assign outstanding = expected_readings.size();

  // Apply the 10 percent jump check to a new frequency and update the display.
  function automatic void take_frequency(input logic [63:0] freq);
    logic jump;
    jump = (freq * 10 < last_freq * 9) || (freq * 10 > last_freq * 11);
    if (!jump) begin
      shown_freq = freq[47:0];
    end
    shown_jump = jump;
    last_freq  = {16'd0, freq[47:0]};
  endfunction

  // Work out the reading that one count word yields.
  function automatic fpm_pkg::result_t meter_reading(input fpm_pkg::item_t w);
    fpm_pkg::result_t r;
    logic [63:0]      scale;
    logic [63:0]      num;
    logic [63:0]      freq;
    logic [1:0]       per;
    logic             fresh;
    fresh = 1'b0;
    if (w.action == fpm_tb_pkg::ACT_GATE) begin
      if (!in_period_mode) begin
        if (w.count < fpm_tb_pkg::LOW_COUNT_LIMIT) begin
          in_period_mode = 1'b1;
        end else begin
          scale = 64'd10000;
          if (cfg_enabled) begin
            if (cfg_gate_sel == fpm_tb_pkg::GATE_SEL_X1) begin
              scale = 64'd1000;
            end else if (cfg_gate_sel != fpm_tb_pkg::GATE_SEL_X10) begin
              scale = 64'd100;
            end
          end
          take_frequency(64'(w.count) * scale);
          fresh = 1'b1;
        end
      end
    end else if (in_period_mode) begin
      // Reference in mHz times the averaged periods; 1e6 Hz x1 when disabled.
      num = 64'd1_000_000_000;
      if (cfg_enabled) begin
        num = 64'd100_000_000;
        per = (cfg_per_sel > fpm_tb_pkg::PER_SEL_X100) ? fpm_tb_pkg::PER_SEL_X100
                                                        : cfg_per_sel;
        repeat (int'(cfg_ref_sel)) num = num * 10;
        repeat (int'(per)) num = num * 10;
      end
      freq = (w.count == 0) ? 64'd0 : num / 64'(w.count);
      take_frequency(freq);
      in_period_mode = 1'b0;
      fresh = 1'b1;
    end
    r.freq_mhz = shown_freq;
    r.is_error = shown_jump;
    r.updated  = fresh;
    return r;
  endfunction

  // Sample the channels at each rising edge.
  always @(posedge clk) begin
    if (rst) begin
      cfg_enabled    = 1'b0;
      cfg_gate_sel   = '0;
      cfg_ref_sel    = '0;
      cfg_per_sel    = '0;
      in_period_mode = 1'b0;
      last_freq      = '0;
      shown_freq     = '0;
      shown_jump     = 1'b0;
      fail_count     = 0;
      expected_readings.delete();
    end else begin
      // Register writes.
      if (psel && penable && pwrite && pready) begin
        case (int'(paddr[3:2]))
          fpm_tb_pkg::REG_METER_ENABLED: cfg_enabled  = pwdata[0];
          fpm_tb_pkg::REG_GATE_TIME:     cfg_gate_sel = pwdata[1:0];
          fpm_tb_pkg::REG_REF_CLOCK:     cfg_ref_sel  = pwdata[1:0];
          fpm_tb_pkg::REG_PERIODS:       cfg_per_sel  = pwdata[1:0];
          default: ;
        endcase
      end

      // Result words are matched against the oldest reading owed.
      if (result_valid && result_ready) begin
        if (expected_readings.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("%0t: unexpected result word freq_mhz=%0d is_error=%0b updated=%0b",
                     $realtime, result.freq_mhz, result.is_error, result.updated);
          end
        end else begin
          owed = expected_readings.pop_front();
          if (result.freq_mhz !== owed.freq_mhz || result.is_error !== owed.is_error ||
              result.updated !== owed.updated) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("%0t: result mismatch: expected freq_mhz=%0d is_error=%0b updated=%0b",
                       $realtime, owed.freq_mhz, owed.is_error, owed.updated);
              $display("%0t:                  got      freq_mhz=%0d is_error=%0b updated=%0b",
                       $realtime, result.freq_mhz, result.is_error, result.updated);
            end
          end
        end
      end

      // Each accepted count word owes one result word.
      if (item_valid && item_ready) begin
        expected_readings.push_back(meter_reading(item));
      end
    end
  end

endmodule

/* dv/freq_period_meter_with_jump_check_tb.sv */
// ----------------------------------------------------------------------------
// freq_period_meter_with_jump_check_tb: testbench top of the meter
// Drives directed and random gate and period count words under several
// register settings, with random gaps on the sender and random stalls on
// the receiver. The checker beside the block scores every result word.
// ----------------------------------------------------------------------------
module freq_period_meter_with_jump_check_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD   = 20;
  localparam int CYCLE_LIMIT  = 400_000;
  localparam int PHASES       = 10;
  localparam int WORDS_PER_PH = 90;
  localparam int SETTLE       = 64;

  logic             clk = 1'b0;
  logic             rst;
  logic             item_valid;
  logic             item_ready;
  fpm_pkg::item_t   item;
  logic             result_valid;
  logic             result_ready;
  fpm_pkg::result_t result;
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [3:0]       paddr;
  logic [31:0]      pwdata;
  logic [31:0]      prdata;
  logic             pready;
  int               mismatches;
  int               outstanding;

  // Stimulus bookkeeping: the mode the meter should be in and recent counts.
  logic        meter_in_period;
  logic        no_idle;
  logic [31:0] last_gate;
  logic [31:0] last_period;
  int          live_words;
  int          cycles;

  freq_period_meter_with_jump_check DUT (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_ready  (item_ready),
    .item        (item),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result      (result),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  freq_period_meter_with_jump_check_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_ready  (item_ready),
    .item        (item),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result      (result),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .pready      (pready),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Receiver: stalls a random number of cycles before each result word.
  initial begin
    int stall;
    result_ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 5);
      if (stall > 0) begin
        result_ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      result_ready = 1'b1;
      do @(posedge clk); while (!result_valid);
      @(negedge clk);
    end
  end

  // Send one word; called at a falling edge and returns at a falling edge.
  task automatic send_word(input fpm_tb_pkg::action_e act, input logic [31:0] cnt);
    int gap;
    if ((act == fpm_tb_pkg::ACT_GATE) != meter_in_period) begin
      live_words++;
    end
    if (act == fpm_tb_pkg::ACT_GATE && !meter_in_period &&
        cnt < fpm_tb_pkg::LOW_COUNT_LIMIT) begin
      meter_in_period = 1'b1;
    end else if (act == fpm_tb_pkg::ACT_PERIOD && meter_in_period) begin
      meter_in_period = 1'b0;
    end
    gap = no_idle ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      item_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    item.action = act;
    item.count  = cnt;
    item_valid  = 1'b1;
    do @(posedge clk); while (!item_ready);
    @(negedge clk);
  endtask

  // Write one register through a port transfer with a setup and an access phase.
  task automatic write_reg(input int idx, input logic [1:0] val);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = 4'(idx * 4);
    pwdata  = {30'd0, val};
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // Let the meter drain, then load all four registers.
  task automatic load_setting(input logic en, input logic [1:0] gate_sel,
                              input logic [1:0] ref_sel, input logic [1:0] per_sel);
    item_valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    write_reg(fpm_tb_pkg::REG_METER_ENABLED, {1'b0, en});
    write_reg(fpm_tb_pkg::REG_GATE_TIME, gate_sel);
    write_reg(fpm_tb_pkg::REG_REF_CLOCK, ref_sel);
    write_reg(fpm_tb_pkg::REG_PERIODS, per_sel);
  endtask

  // A count within about 12 percent of an earlier one, so jumps stay rare.
  function automatic logic [31:0] nearby(input logic [31:0] x);
    logic [63:0] v;
    v = 64'(x) * (88 + $urandom_range(0, 24)) / 100;
    return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
  endfunction

  // One random step: mostly well-formed measurements, some stray words.
  task automatic random_step();
    int          pick;
    logic [31:0] c;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      send_word(($urandom_range(0, 1) != 0) ? fpm_tb_pkg::ACT_PERIOD
                                            : fpm_tb_pkg::ACT_GATE, $urandom);
    end else if (!meter_in_period) begin
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
        c = $urandom_range(0, fpm_tb_pkg::LOW_COUNT_LIMIT - 1);
      end else if (pick < 65) begin
        c = nearby(last_gate);
      end else if (pick < 85) begin
        c = $urandom_range(fpm_tb_pkg::LOW_COUNT_LIMIT, 200_000);
      end else begin
        c = $urandom;
      end
      if (c >= fpm_tb_pkg::LOW_COUNT_LIMIT) begin
        last_gate = c;
      end
      send_word(fpm_tb_pkg::ACT_GATE, c);
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
        c = '0;
      end else if (pick < 55) begin
        c = nearby(last_period);
      end else if (pick < 75) begin
        c = $urandom_range(1, 100_000);
      end else begin
        c = $urandom;
      end
      if (c != 0) begin
        last_period = c;
      end
      send_word(fpm_tb_pkg::ACT_PERIOD, c);
    end
  endtask

  // Main stimulus and verdict.
  initial begin
    int goal;
    rst             = 1'b1;
    item_valid      = 1'b0;
    item            = '0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    meter_in_period = 1'b0;
    no_idle         = 1'b0;
    last_gate       = 32'd5000;
    last_period     = 32'd50_000;
    live_words      = 0;
    cycles          = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed words with the reset setting: fixed default scales.
    send_word(fpm_tb_pkg::ACT_PERIOD, 32'd5);        // stray period count in gate mode
    send_word(fpm_tb_pkg::ACT_GATE, 32'd1000);       // first value after reset jumps
    send_word(fpm_tb_pkg::ACT_GATE, 32'd1000);       // steady value
    send_word(fpm_tb_pkg::ACT_GATE, 32'd1100);       // exactly 10 percent up
    send_word(fpm_tb_pkg::ACT_GATE, 32'd10000);
    send_word(fpm_tb_pkg::ACT_GATE, 32'd9000);       // exactly 10 percent down
    send_word(fpm_tb_pkg::ACT_GATE, 32'd8099);       // just past the band
    send_word(fpm_tb_pkg::ACT_GATE, 32'd999);        // low count enters period mode
    send_word(fpm_tb_pkg::ACT_GATE, 32'd5000);       // gate count ignored in period mode
    send_word(fpm_tb_pkg::ACT_PERIOD, 32'd0);        // zero period count
    send_word(fpm_tb_pkg::ACT_GATE, 32'd0);
    send_word(fpm_tb_pkg::ACT_PERIOD, 32'd1);
    send_word(fpm_tb_pkg::ACT_GATE, 32'd1);
    send_word(fpm_tb_pkg::ACT_PERIOD, 32'hFFFF_FFFF);
    send_word(fpm_tb_pkg::ACT_GATE, 32'hFFFF_FFFF);  // largest gate count
    send_word(fpm_tb_pkg::ACT_GATE, 32'hFFFF_FFFF);

    // Largest scales, with the saturating selector codes.
    load_setting(1'b1, fpm_tb_pkg::SEL_SATURATING, fpm_tb_pkg::REF_SEL_100M,
                 fpm_tb_pkg::SEL_SATURATING);
    send_word(fpm_tb_pkg::ACT_GATE, 32'hFFFF_FFFF);
    send_word(fpm_tb_pkg::ACT_GATE, 32'd0);
    send_word(fpm_tb_pkg::ACT_PERIOD, 32'd1);        // largest period-mode frequency
    send_word(fpm_tb_pkg::ACT_GATE, 32'd998);
    send_word(fpm_tb_pkg::ACT_PERIOD, 32'hFFFF_FFFF);
    send_word(fpm_tb_pkg::ACT_GATE, 32'd1000);

    // Random phases, each under its own setting.
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: load_setting(1'b1, fpm_tb_pkg::GATE_SEL_X10, fpm_tb_pkg::REF_SEL_100K,
                        fpm_tb_pkg::PER_SEL_X1);
        1: load_setting(1'b1, fpm_tb_pkg::GATE_SEL_X0P1, fpm_tb_pkg::REF_SEL_100M,
                        fpm_tb_pkg::PER_SEL_X100);
        2: load_setting(1'b0, fpm_tb_pkg::SEL_SATURATING, fpm_tb_pkg::REF_SEL_100M,
                        fpm_tb_pkg::SEL_SATURATING);
        3: load_setting(1'b1, fpm_tb_pkg::GATE_SEL_X1, fpm_tb_pkg::REF_SEL_100K,
                        fpm_tb_pkg::SEL_SATURATING);
        default: load_setting(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                              2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)));
      endcase
      no_idle = (ph % 4 == 3);
      goal = live_words + WORDS_PER_PH;
      while (live_words < goal) random_step();
    end

    // Drain and settle.
    item_valid = 1'b0;
    no_idle    = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
